>>> sv/tile_animation_frame_resolver_assert.svh
// ---------------------------------------------------------------------------
// tile animation frame resolver assertion macros
// concurrent assertion wrappers, compiled out when NO_ASSERTIONS is set
// ---------------------------------------------------------------------------
`ifndef TILE_ANIMATION_FRAME_RESOLVER_ASSERT_SVH
`define TILE_ANIMATION_FRAME_RESOLVER_ASSERT_SVH
`ifndef NO_ASSERTIONS
// checked outside reset only
`define TAFR_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);
// checked at every edge, reset included
`define TAFR_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) (prop)) else $error(msg);
`else
`define TAFR_ASSERT(lbl, prop, msg)
`define TAFR_ASSERT_ALWAYS(lbl, prop, msg)
`endif
`endif

>>> sv/tafr_pkg.sv
// ---------------------------------------------------------------------------
// tafr_pkg
// shared sizes, command codes and queue item type of the frame resolver
// ---------------------------------------------------------------------------
`default_nettype none

package tafr_pkg;

  localparam int ANIM_ENTRIES = 64;
  localparam int FRAME_SLOTS  = 256;

  localparam int EntryAw = (ANIM_ENTRIES > 1) ? $clog2(ANIM_ENTRIES) : 1;
  localparam int FrameAw = (FRAME_SLOTS > 1) ? $clog2(FRAME_SLOTS) : 1;
  localparam int EntryCw = $clog2(ANIM_ENTRIES + 1);

  typedef enum logic [1:0] {
    CMD_WR_ENTRY = 2'd0,
    CMD_WR_FRAME = 2'd1,
    CMD_RESOLVE  = 2'd2,
    CMD_UNUSED   = 2'd3
  } cmd_e;

  typedef struct packed {
    cmd_e        kind;
    logic [7:0]  slot;
    logic [15:0] tile_id;
    logic        entry_valid;
    logic [7:0]  first_frame;
    logic [8:0]  frame_total;
    logic [23:0] cycle_length_ms;
    logic [15:0] frame_length_ms;
    logic [31:0] time_ms;
  } item_t;

  // queue head as seen by the back end
  typedef struct packed {
    logic  valid;
    item_t item;
  } q_head_t;

endpackage

`default_nettype wire

>>> sv/tile_animation_frame_resolver.sv
// ---------------------------------------------------------------------------
// tile animation frame resolver
// maps a tile id and a time to the frame tile of its animation entry
// ---------------------------------------------------------------------------
//  channel  dir  tdata                                  tuser
//  s_axis   in   slot..time_ms (114 bits in 120)        command
//  m_axis   out  resolved_tile                          was_animated
//
// write commands are popped and applied from the idle state
// a resolve runs from queue pop to result register as a key scan reading one
// table entry per cycle, a 32-step modulo and one frame read per cycle; no
// match, or a match with no frames or zero cycle, skips the modulo and walk
// and returns the tile id unanimated
// reset clears the live marks, the queue and the output register at once
// a two-deep queue lets input keep flowing while the back end or output stalls
`default_nettype none
`include "tile_animation_frame_resolver_assert.svh"

module tile_animation_frame_resolver import tafr_pkg::*; (
  input  wire logic         clk_i,
  input  wire logic         rst_ni,
  input  wire logic         s_axis_tvalid,
  output logic              s_axis_tready,
  // [7:0] slot, [23:8] tile_id, [24] entry_valid, [32:25] first_frame,
  // [41:33] frame_total, [65:42] cycle_length_ms, [81:66] frame_length_ms,
  // [113:82] time_ms, [119:114] zero
  input  wire logic [119:0] s_axis_tdata,
  // [1:0] command
  input  wire logic [1:0]   s_axis_tuser,
  output logic              m_axis_tvalid,
  input  wire logic         m_axis_tready,
  // [15:0] resolved_tile
  output logic [15:0]       m_axis_tdata,
  // [0] was_animated
  output logic              m_axis_tuser
);

  item_t      in_item;
  q_head_t    head;
  logic       pop;
  logic [1:0] level;

  // unpack the incoming transaction
  always_comb begin
    in_item.kind            = cmd_e'(s_axis_tuser);
    in_item.slot            = s_axis_tdata[7:0];
    in_item.tile_id         = s_axis_tdata[23:8];
    in_item.entry_valid     = s_axis_tdata[24];
    in_item.first_frame     = s_axis_tdata[32:25];
    in_item.frame_total     = s_axis_tdata[41:33];
    in_item.cycle_length_ms = s_axis_tdata[65:42];
    in_item.frame_length_ms = s_axis_tdata[81:66];
    in_item.time_ms         = s_axis_tdata[113:82];
  end

  tafr_front u_front (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .s_valid_i (s_axis_tvalid),
    .s_ready_o (s_axis_tready),
    .item_i    (in_item),
    .head_o    (head),
    .pop_i     (pop),
    .level_o   (level)
  );

  tafr_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .head_i      (head),
    .pop_o       (pop),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .out_tile_o  (m_axis_tdata),
    .out_anim_o  (m_axis_tuser)
  );

  // queue never overfills and is only drained when it holds something
  `TAFR_ASSERT(a_level_max, level != 2'd3, "queue level out of range")
  `TAFR_ASSERT(a_pop_nonempty, pop |-> head.valid, "pop from empty queue")
  `TAFR_ASSERT(a_ready_level, s_axis_tready == (level != 2'd2), "ready disagrees with level")
  `TAFR_ASSERT_ALWAYS(a_rst_quiet, !rst_ni |=> !m_axis_tvalid, "output valid after reset")

endmodule

`default_nettype wire

>>> sv/tafr_front.sv
// ---------------------------------------------------------------------------
// tafr_front
// accepts transactions, drops the ones with no effect, queues the rest
// ---------------------------------------------------------------------------
`default_nettype none

module tafr_front import tafr_pkg::*; (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          s_valid_i,
  output logic               s_ready_o,
  input  wire item_t         item_i,
  output q_head_t            head_o,
  input  wire logic          pop_i,
  output logic [1:0]         level_o
);

  item_t      q_mem [2];
  logic       wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [1:0] level_q, level_d;
  logic       keep, push;

  // classify: unused command and out-of-range slots change nothing
  always_comb begin
    unique case (item_i.kind)
      CMD_WR_ENTRY: keep = (32'(item_i.slot) < 32'(ANIM_ENTRIES));
      CMD_WR_FRAME: keep = (32'(item_i.slot) < 32'(FRAME_SLOTS));
      CMD_RESOLVE:  keep = 1'b1;
      default:      keep = 1'b0;
    endcase
  end

  assign s_ready_o = (level_q != 2'd2);
  assign push      = s_valid_i && s_ready_o && keep;

  // pointer and fill level
  always_comb begin
    wr_ptr_d = push ? ~wr_ptr_q : wr_ptr_q;
    rd_ptr_d = pop_i ? ~rd_ptr_q : rd_ptr_q;
    level_d  = level_q + 2'(push) - 2'(pop_i);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      level_q  <= 2'd0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      level_q  <= level_d;
    end
  end

  // queue storage
  always_ff @(posedge clk_i) begin
    if (push) begin
      q_mem[wr_ptr_q] <= item_i;
    end
  end

  assign head_o.valid = (level_q != 2'd0);
  assign head_o.item  = q_mem[rd_ptr_q];
  assign level_o      = level_q;

endmodule

`default_nettype wire

>>> sv/tafr_back.sv
// ---------------------------------------------------------------------------
// tafr_back
// executes queued commands: table writes, key search, modulo and frame walk
// ---------------------------------------------------------------------------
`default_nettype none

module tafr_back import tafr_pkg::*; (
  input  wire logic    clk_i,
  input  wire logic    rst_ni,
  input  wire q_head_t head_i,
  output logic         pop_o,
  output logic         out_valid_o,
  input  wire logic    out_ready_i,
  output logic [15:0]  out_tile_o,
  output logic         out_anim_o
);

  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_SCAN = 3'd1;
  localparam logic [2:0] ST_DIV  = 3'd2;
  localparam logic [2:0] ST_WALK = 3'd3;
  localparam logic [2:0] ST_OUT  = 3'd4;

  typedef struct packed {
    logic [15:0] key;
    logic [7:0]  first;
    logic [8:0]  count;
    logic [23:0] cycle;
  } entry_t;

  typedef struct packed {
    logic [15:0] tile;
    logic [15:0] len;
  } frame_t;

  entry_t ent_mem [ANIM_ENTRIES];
  frame_t fr_mem  [FRAME_SLOTS];

  logic [2:0]            state_q, state_d;
  logic [ANIM_ENTRIES-1:0] live_q, live_d;
  logic [15:0]           tile_q, tile_d;
  logic [31:0]           dvd_q, dvd_d;
  logic [EntryCw-1:0]    cnt_q, cnt_d;
  entry_t                ent_rd_q;
  logic [EntryAw-1:0]    rd_idx_q;
  logic                  rd_vld_q, rd_vld_d;
  logic                  rd_en;
  logic [8:0]            count_q, count_d;
  logic [23:0]           cycle_q, cycle_d;
  logic [23:0]           rem_q, rem_d;
  logic [5:0]            step_q, step_d;
  logic [7:0]            red_q, red_d;
  logic [FrameAw-1:0]    fp_q, fp_d;
  logic [8:0]            issued_q, issued_d, taken_q, taken_d;
  logic [24:0]           sum_q, sum_d;
  frame_t                fr_rd_q;
  logic                  fr_vld_q, fr_vld_d, fr_en;
  logic [15:0]           res_tile_q, res_tile_d;
  logic                  res_anim_q, res_anim_d;
  logic                  out_vld_q, out_vld_d;
  logic [15:0]           out_tile_q, out_tile_d;
  logic                  out_anim_q, out_anim_d;
  logic                  match, red_ok, load_out, ent_we, fr_we;
  logic [24:0]           trial, walk_sum;

  assign match    = rd_vld_q && live_q[rd_idx_q] && (ent_rd_q.key == tile_q);
  assign red_ok   = (32'(red_q) < 32'(FRAME_SLOTS));
  assign trial    = {rem_q, dvd_q[31]};
  assign walk_sum = sum_q + 25'(fr_rd_q.len);
  assign load_out = (state_q == ST_OUT) && (!out_vld_q || out_ready_i);
  assign ent_we   = (state_q == ST_IDLE) && head_i.valid && (head_i.item.kind == CMD_WR_ENTRY);
  assign fr_we    = (state_q == ST_IDLE) && head_i.valid && (head_i.item.kind == CMD_WR_FRAME);
  assign rd_en    = (state_q == ST_SCAN) && (32'(cnt_q) < 32'(ANIM_ENTRIES));
  assign fr_en    = (state_q == ST_WALK) && (issued_q != count_q);

  // sequencer
  always_comb begin
    state_d    = state_q;
    live_d     = live_q;
    tile_d     = tile_q;
    dvd_d      = dvd_q;
    cnt_d      = cnt_q;
    rd_vld_d   = rd_en;
    count_d    = count_q;
    cycle_d    = cycle_q;
    rem_d      = rem_q;
    step_d     = step_q;
    red_d      = red_q;
    fp_d       = fp_q;
    issued_d   = issued_q;
    taken_d    = taken_q;
    sum_d      = sum_q;
    fr_vld_d   = fr_en;
    res_tile_d = res_tile_q;
    res_anim_d = res_anim_q;
    pop_o      = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        if (head_i.valid) begin
          pop_o = 1'b1;
          if (head_i.item.kind == CMD_WR_ENTRY) begin
            live_d[EntryAw'(head_i.item.slot)] = head_i.item.entry_valid;
          end else if (head_i.item.kind == CMD_RESOLVE) begin
            tile_d  = head_i.item.tile_id;
            dvd_d   = head_i.item.time_ms;
            cnt_d   = '0;
            state_d = ST_SCAN;
          end
        end
      end
      ST_SCAN: begin
        if (rd_en) begin
          cnt_d = cnt_q + EntryCw'(1);
        end
        // lowest slot wins: first match ends the search
        if (match) begin
          rd_vld_d = 1'b0;
          if ((ent_rd_q.count != 9'd0) && (ent_rd_q.cycle != 24'd0)) begin
            count_d = ent_rd_q.count;
            cycle_d = ent_rd_q.cycle;
            red_d   = ent_rd_q.first;
            rem_d   = '0;
            step_d  = '0;
            state_d = ST_DIV;
          end else begin
            res_tile_d = tile_q;
            res_anim_d = 1'b0;
            state_d    = ST_OUT;
          end
        end else if (!rd_vld_q && !rd_en && (cnt_q != '0)) begin
          res_tile_d = tile_q;
          res_anim_d = 1'b0;
          state_d    = ST_OUT;
        end
      end
      ST_DIV: begin
        // restoring division, one quotient bit per cycle
        if (step_q != 6'd32) begin
          rem_d  = (trial >= {1'b0, cycle_q}) ? 24'(trial - {1'b0, cycle_q}) : 24'(trial);
          dvd_d  = {dvd_q[30:0], 1'b0};
          step_d = step_q + 6'd1;
        end
        // first frame index brought into the store range
        if (!red_ok) begin
          red_d = red_q - 8'(FRAME_SLOTS);
        end
        if ((step_q == 6'd32) && red_ok) begin
          fp_d     = FrameAw'(red_q);
          issued_d = '0;
          taken_d  = '0;
          sum_d    = '0;
          state_d  = ST_WALK;
        end
      end
      ST_WALK: begin
        if (fr_en) begin
          fp_d     = (fp_q == FrameAw'(FRAME_SLOTS - 1)) ? '0 : fp_q + FrameAw'(1);
          issued_d = issued_q + 9'd1;
        end
        if (fr_vld_q) begin
          sum_d      = walk_sum;
          taken_d    = taken_q + 9'd1;
          res_tile_d = fr_rd_q.tile;
          res_anim_d = 1'b1;
          if (({1'b0, rem_q} < walk_sum) || (taken_q + 9'd1 == count_q)) begin
            fr_vld_d = 1'b0;
            state_d  = ST_OUT;
          end
        end
      end
      ST_OUT: begin
        if (load_out) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // output register
  always_comb begin
    out_vld_d  = out_vld_q && !out_ready_i;
    out_tile_d = out_tile_q;
    out_anim_d = out_anim_q;
    if (load_out) begin
      out_vld_d  = 1'b1;
      out_tile_d = res_tile_q;
      out_anim_d = res_anim_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      live_q    <= '0;
      out_vld_q <= 1'b0;
      rd_vld_q  <= 1'b0;
      fr_vld_q  <= 1'b0;
    end else begin
      state_q   <= state_d;
      live_q    <= live_d;
      out_vld_q <= out_vld_d;
      rd_vld_q  <= rd_vld_d;
      fr_vld_q  <= fr_vld_d;
    end
  end

  // datapath registers
  always_ff @(posedge clk_i) begin
    tile_q     <= tile_d;
    dvd_q      <= dvd_d;
    cnt_q      <= cnt_d;
    count_q    <= count_d;
    cycle_q    <= cycle_d;
    rem_q      <= rem_d;
    step_q     <= step_d;
    red_q      <= red_d;
    fp_q       <= fp_d;
    issued_q   <= issued_d;
    taken_q    <= taken_d;
    sum_q      <= sum_d;
    res_tile_q <= res_tile_d;
    res_anim_q <= res_anim_d;
    out_tile_q <= out_tile_d;
    out_anim_q <= out_anim_d;
  end

  // entry table memory
  always_ff @(posedge clk_i) begin
    if (ent_we) begin
      ent_mem[EntryAw'(head_i.item.slot)] <= '{key:   head_i.item.tile_id,
                                              first: head_i.item.first_frame,
                                              count: head_i.item.frame_total,
                                              cycle: head_i.item.cycle_length_ms};
    end
    if (rd_en) begin
      ent_rd_q <= ent_mem[EntryAw'(cnt_q)];
      rd_idx_q <= EntryAw'(cnt_q);
    end
  end

  // frame store memory
  always_ff @(posedge clk_i) begin
    if (fr_we) begin
      fr_mem[FrameAw'(head_i.item.slot)] <= '{tile: head_i.item.tile_id,
                                              len:  head_i.item.frame_length_ms};
    end
    if (fr_en) begin
      fr_rd_q <= fr_mem[fp_q];
    end
  end

  assign out_valid_o = out_vld_q;
  assign out_tile_o  = out_tile_q;
  assign out_anim_o  = out_anim_q;

endmodule

`default_nettype wire

>>> tb/sv/tile_animation_frame_resolver_tb.sv
// ---------------------------------------------------------------------------
// tile animation frame resolver testbench
// drives entry and frame writes and resolve queries, predicts each resolved
// tile from a local copy of the tables and checks the result stream in order
// ---------------------------------------------------------------------------
`default_nettype none

module tile_animation_frame_resolver_tb import tafr_pkg::*;;

  logic         clk_i = 1'b0;
  logic         rst_ni = 1'b0;
  logic         s_axis_tvalid = 1'b0;
  logic         s_axis_tready;
  logic [119:0] s_axis_tdata = '0;
  logic [1:0]   s_axis_tuser = '0;
  logic         m_axis_tvalid;
  logic         m_axis_tready = 1'b0;
  logic [15:0]  m_axis_tdata;
  logic         m_axis_tuser;

  // predictor copy of the tables
  logic [15:0] key_tab [ANIM_ENTRIES];
  logic        live_tab [ANIM_ENTRIES];
  logic [7:0]  first_tab [ANIM_ENTRIES];
  logic [8:0]  count_tab [ANIM_ENTRIES];
  logic [23:0] cycle_tab [ANIM_ENTRIES];
  logic [15:0] ftile_tab [FRAME_SLOTS];
  logic [15:0] flen_tab [FRAME_SLOTS];

  typedef struct packed {
    logic [15:0] tile;
    logic        animated;
  } tile_res_t;

  tile_res_t pending_tiles[$];
  bit        failed = 1'b0;
  int        send_idle_pct = 0;
  int        recv_stall_pct = 0;

  tile_animation_frame_resolver dut (.*);

  always #6 clk_i = ~clk_i;

  // receiver ready with random stalls
  always @(posedge clk_i) begin
    m_axis_tready <= ($urandom_range(99) >= recv_stall_pct);
  end

  // result checker
  always @(posedge clk_i) begin
    tile_res_t exp_r;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (pending_tiles.size() == 0) begin
        $error("unexpected result tile %0h", m_axis_tdata);
        failed = 1'b1;
      end else begin
        exp_r = pending_tiles.pop_front();
        if (m_axis_tdata !== exp_r.tile) begin
          $error("resolved_tile expected %0h actual %0h", exp_r.tile, m_axis_tdata);
          failed = 1'b1;
        end
        if (m_axis_tuser !== exp_r.animated) begin
          $error("was_animated expected %0b actual %0b", exp_r.animated, m_axis_tuser);
          failed = 1'b1;
        end
      end
    end
  end

  // update the tables or compute the expected tile for one transaction
  function automatic void predict_item(item_t it);
    tile_res_t r;
    int        e;
    int        hit_e;
    logic [EntryAw-1:0] es;
    logic [EntryAw-1:0] hx;
    logic [31:0] phase;
    logic [31:0] acc;
    logic [7:0]  fi;
    bit          hit;
    hit_e = -1;
    acc = '0;
    hit = 1'b0;
    es = EntryAw'(it.slot);
    hx = '0;
    case (it.kind)
      CMD_WR_ENTRY: if (it.slot < ANIM_ENTRIES) begin
        key_tab[es] = it.tile_id;
        live_tab[es] = it.entry_valid;
        first_tab[es] = it.first_frame;
        count_tab[es] = it.frame_total;
        cycle_tab[es] = it.cycle_length_ms;
      end
      CMD_WR_FRAME: begin
        ftile_tab[it.slot] = it.tile_id;
        flen_tab[it.slot] = it.frame_length_ms;
      end
      CMD_RESOLVE: begin
        r.tile = it.tile_id;
        r.animated = 1'b0;
        for (e = 0; e < ANIM_ENTRIES; e++)
          if (hit_e < 0 && live_tab[EntryAw'(e)] && key_tab[EntryAw'(e)] == it.tile_id)
            hit_e = e;
        if (hit_e >= 0) hx = EntryAw'(hit_e);
        if (hit_e >= 0 && count_tab[hx] != 0 && cycle_tab[hx] != 0) begin
          phase = it.time_ms % {8'd0, cycle_tab[hx]};
          for (e = 0; e < count_tab[hx] && !hit; e++) begin
            fi = first_tab[hx] + e[7:0];
            acc = acc + flen_tab[fi];
            if (phase < acc) begin
              r.tile = ftile_tab[fi];
              hit = 1'b1;
            end
          end
          if (!hit) r.tile = ftile_tab[8'(first_tab[hx] + count_tab[hx] - 1)];
          r.animated = 1'b1;
        end
        pending_tiles.push_back(r);
      end
      default: ;
    endcase
  endfunction

  // send one transaction, waiting for the handshake
  task automatic send_item(item_t it);
    while ($urandom_range(99) < send_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser <= it.kind;
    s_axis_tdata <= {6'd0, it.time_ms, it.frame_length_ms, it.cycle_length_ms,
                     it.frame_total, it.first_frame, it.entry_valid, it.tile_id, it.slot};
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    predict_item(it);
  endtask

  function automatic item_t rand_fields();
    item_t it;
    it.kind = cmd_e'($urandom_range(3));
    it.slot = 8'($urandom);
    it.tile_id = 16'($urandom);
    it.entry_valid = 1'($urandom);
    it.first_frame = 8'($urandom);
    it.frame_total = 9'($urandom);
    it.cycle_length_ms = 24'($urandom);
    it.frame_length_ms = 16'($urandom);
    it.time_ms = $urandom;
    return it;
  endfunction

  task automatic write_frame(int s, logic [15:0] t, logic [15:0] len);
    item_t it;
    it = rand_fields();
    it.kind = CMD_WR_FRAME;
    it.slot = 8'(s);
    it.tile_id = t;
    it.frame_length_ms = len;
    send_item(it);
  endtask

  task automatic write_entry(int s, logic [15:0] k, logic v, logic [7:0] f,
                             logic [8:0] n, logic [23:0] c);
    item_t it;
    it = rand_fields();
    it.kind = CMD_WR_ENTRY;
    it.slot = 8'(s);
    it.tile_id = k;
    it.entry_valid = v;
    it.first_frame = f;
    it.frame_total = n;
    it.cycle_length_ms = c;
    send_item(it);
  endtask

  task automatic resolve(logic [15:0] t, logic [31:0] tm);
    item_t it;
    it = rand_fields();
    it.kind = CMD_RESOLVE;
    it.tile_id = t;
    it.time_ms = tm;
    send_item(it);
  endtask

  // fill every frame slot so no resolve reads an unwritten frame
  task automatic test_frame_fill();
    int i;
    for (i = 0; i < FRAME_SLOTS; i++)
      write_frame(i, 16'($urandom), 16'($urandom_range(1, 400)));
  endtask

  // extremes, match priority, wrap, zero cycle, no frames, unused command
  task automatic test_directed();
    item_t it;
    resolve(16'hffff, 32'hffff_ffff);
    write_entry(0, 16'h0000, 1'b1, 8'd250, 9'd10, 24'd500);
    write_entry(63, 16'hffff, 1'b1, 8'd255, 9'd511, 24'hffffff);
    write_entry(1, 16'h0000, 1'b1, 8'd3, 9'd2, 24'd7);
    write_entry(64, 16'h1234, 1'b1, 8'd0, 9'd1, 24'd1);
    write_entry(2, 16'h0042, 1'b1, 8'd0, 9'd0, 24'd100);
    write_entry(3, 16'h0043, 1'b1, 8'd0, 9'd4, 24'd0);
    write_entry(4, 16'h0044, 1'b0, 8'd0, 9'd4, 24'd10);
    write_frame(255, 16'hffff, 16'hffff);
    write_frame(5, 16'h0000, 16'h0000);
    resolve(16'h0000, 32'd0);
    resolve(16'h0000, 32'hffff_ffff);
    resolve(16'hffff, 32'hffff_ffff);
    resolve(16'hffff, 32'd0);
    resolve(16'h1234, 32'd5);
    resolve(16'h0042, 32'd5);
    resolve(16'h0043, 32'd5);
    resolve(16'h0044, 32'd5);
    it = rand_fields();
    it.kind = CMD_UNUSED;
    send_item(it);
    resolve(16'h0000, 32'd123);
  endtask

  // random traffic, mostly resolves against a small key set
  task automatic test_random(int n, int idle, int stall);
    item_t it;
    int i;
    send_idle_pct = idle;
    recv_stall_pct = stall;
    for (i = 0; i < n; i++) begin
      it = rand_fields();
      case ($urandom_range(9))
        0: it.kind = CMD_WR_ENTRY;
        1: it.kind = CMD_WR_FRAME;
        2: ;
        default: it.kind = CMD_RESOLVE;
      endcase
      if (it.kind == CMD_WR_ENTRY || (it.kind == CMD_RESOLVE && $urandom_range(3) != 0))
        it.tile_id = 16'($urandom_range(7));
      if ($urandom_range(3) != 0) it.frame_total = 9'($urandom_range(12));
      if ($urandom_range(3) != 0) it.cycle_length_ms = 24'($urandom_range(3000));
      if (it.kind == CMD_WR_FRAME && $urandom_range(1))
        it.frame_length_ms = 16'($urandom_range(300));
      send_item(it);
    end
  endtask

  initial begin
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_frame_fill();
    test_directed();
    test_random(500, 0, 0);
    test_random(400, 84, 0);
    test_random(400, 0, 84);
    test_random(400, 11, 11);
    s_axis_tvalid <= 1'b0;
    send_idle_pct = 0;
    recv_stall_pct = 0;
    while (pending_tiles.size() != 0) @(posedge clk_i);
    repeat (200) @(posedge clk_i);
    if (!failed && pending_tiles.size() == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

  // run limit
  initial begin
    #(12 * 10000000);
    $display("Some tests failed");
    $finish;
  end

endmodule

`default_nettype wire

>>> filelist.f
+incdir+sv
sv/tafr_pkg.sv
sv/tafr_front.sv
sv/tafr_back.sv
sv/tile_animation_frame_resolver.sv
tb/sv/tile_animation_frame_resolver_tb.sv
